// File: hdl/pure_pursuit_steering_assert.svh
// Assertion macros for the pure pursuit steering block.
// Used by the port checker; no other dependencies.
`ifndef PURE_PURSUIT_STEERING_ASSERT_SVH
`define PURE_PURSUIT_STEERING_ASSERT_SVH

// clocked assertion, disabled while reset is asserted
`define PPS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked next-cycle implication, disabled while reset is asserted
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ppss_pkg.sv
// Shared types, constants and rounding helpers for pure_pursuit_steering.
// No dependencies.
`timescale 1ns / 1ps

package ppss_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int PTR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PTR_W + 1;
    localparam int CW         = 40;   // CORDIC vector width
    localparam int ZW         = 25;   // Q.20 angle width
    localparam int PW         = 34;   // look-ahead point width
    localparam int CORDIC_N   = 20;

    localparam logic signed [ZW-1:0] ANG_PI      = 25'sd3294199;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 25'sd1647099;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 40'sd652032875;

    localparam logic [1:0] CFG_LOOKAHEAD = 2'd0;
    localparam logic [1:0] CFG_WHEELBASE = 2'd1;
    localparam logic [1:0] CFG_MAXSTEER  = 2'd2;
    localparam logic [1:0] CFG_COUNT     = 2'd3;

    typedef struct packed {
        logic                 start;
        logic                 vec;    // 1 vectoring (atan2), 0 rotation
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_req_t;

    typedef struct packed {
        logic                 done;
        logic                 neg;    // rotation result must be negated
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_rsp_t;

    typedef struct packed {
        logic             done;
        logic [PTR_W-1:0] best;
    } scan_status_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:  r = 25'sd823550;
            5'd1:  r = 25'sd486170;
            5'd2:  r = 25'sd256879;
            5'd3:  r = 25'sd130396;
            5'd4:  r = 25'sd65451;
            5'd5:  r = 25'sd32757;
            5'd6:  r = 25'sd16383;
            5'd7:  r = 25'sd8192;
            5'd8:  r = 25'sd4096;
            5'd9:  r = 25'sd2048;
            5'd10: r = 25'sd1024;
            5'd11: r = 25'sd512;
            5'd12: r = 25'sd256;
            5'd13: r = 25'sd128;
            5'd14: r = 25'sd64;
            5'd15: r = 25'sd32;
            5'd16: r = 25'sd16;
            5'd17: r = 25'sd8;
            5'd18: r = 25'sd4;
            5'd19: r = 25'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // shift right, rounding half away from zero
    function automatic logic signed [CW-1:0] rnd_shr(input logic signed [CW-1:0] v,
                                                     input logic [4:0] s);
        logic signed [CW-1:0] h;
        logic signed [CW-1:0] m;
        h = 40'sd1 <<< (s - 5'd1);
        m = -v;
        if (!v[CW-1])
            return (v + h) >>> s;
        else
            return -((m + h) >>> s);
    endfunction

endpackage

// File: hdl/ppss_path_ram.sv
// Path point store: one write port, one registered read port.
// Depends on ppss_pkg.
`timescale 1ns / 1ps

module ppss_path_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [ppss_pkg::PTR_W-1:0]   waddr,
    input  logic [31:0]                  wx,
    input  logic [31:0]                  wy,
    input  logic [ppss_pkg::PTR_W-1:0]   raddr,
    output logic [31:0]                  rx,
    output logic [31:0]                  ry
);

    logic [63:0] mem [ppss_pkg::MAX_POINTS];
    logic [63:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wy, wx};
        end
        rd_reg <= mem[raddr];
    end

    assign rx = rd_reg[31:0];
    assign ry = rd_reg[63:32];

endmodule

// File: hdl/ppss_cordic.sv
// Shared iterative CORDIC: rotation (cos/sin) or vectoring (atan2), 20 steps.
// Depends on ppss_pkg.
`timescale 1ns / 1ps

module ppss_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppss_pkg::cordic_req_t req,
    output ppss_pkg::cordic_rsp_t rsp
);

    logic                            busy_reg;
    logic                            done_reg;
    logic                            vec_reg;
    logic                            neg_reg;
    logic                            zero_reg;
    logic [4:0]                      it_reg;
    logic signed [ppss_pkg::CW-1:0]  x_reg;
    logic signed [ppss_pkg::CW-1:0]  y_reg;
    logic signed [ppss_pkg::ZW-1:0]  z_reg;

    logic signed [ppss_pkg::CW-1:0]  xs;
    logic signed [ppss_pkg::CW-1:0]  ys;
    logic signed [ppss_pkg::ZW-1:0]  t;
    logic                            p;

    always_comb
    begin
        xs = x_reg >>> it_reg;
        ys = y_reg >>> it_reg;
        t  = ppss_pkg::atan_entry(it_reg);
        p  = vec_reg ? !(y_reg > 0) : !z_reg[ppss_pkg::ZW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + 5'd1;
                if (it_reg == 5'(ppss_pkg::CORDIC_N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            vec_reg <= req.vec;
            if (req.vec)
            begin
                neg_reg  <= 1'b0;
                zero_reg <= (req.x == 0) && (req.y == 0);
                if (req.x[ppss_pkg::CW-1])
                begin
                    x_reg <= -req.x;
                    y_reg <= -req.y;
                    z_reg <= req.y[ppss_pkg::CW-1] ? -ppss_pkg::ANG_PI : ppss_pkg::ANG_PI;
                end
                else
                begin
                    x_reg <= req.x;
                    y_reg <= req.y;
                    z_reg <= '0;
                end
            end
            else
            begin
                zero_reg <= 1'b0;
                x_reg    <= ppss_pkg::CORDIC_GAIN;
                y_reg    <= '0;
                if (req.z > ppss_pkg::ANG_HALF_PI)
                begin
                    z_reg   <= req.z - ppss_pkg::ANG_PI;
                    neg_reg <= 1'b1;
                end
                else if (req.z < -ppss_pkg::ANG_HALF_PI)
                begin
                    z_reg   <= req.z + ppss_pkg::ANG_PI;
                    neg_reg <= 1'b1;
                end
                else
                begin
                    z_reg   <= req.z;
                    neg_reg <= 1'b0;
                end
            end
        end
        else if (busy_reg)
        begin
            if (p)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - t;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + t;
            end
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.neg  = neg_reg;
        rsp.x    = x_reg;
        rsp.y    = y_reg;
        rsp.z    = zero_reg ? '0 : z_reg;
    end

endmodule

// File: hdl/ppss_scan.sv
// Nearest point search: streams slots from the path store through a
// subtract, square, sum and compare pipeline, keeping the first minimum.
// Depends on ppss_pkg.
`timescale 1ns / 1ps

module ppss_scan (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ppss_pkg::CNT_W-1:0]        count,
    input  logic signed [ppss_pkg::PW-1:0]    px,
    input  logic signed [ppss_pkg::PW-1:0]    py,
    input  logic [31:0]                       rx,
    input  logic [31:0]                       ry,
    output logic [ppss_pkg::PTR_W-1:0]        raddr,
    output ppss_pkg::scan_status_t            status
);

    localparam int MW = ppss_pkg::PW;       // magnitude width
    localparam int SW = 2 * MW + 1;         // sum of squares width

    logic                        active_reg;
    logic [ppss_pkg::CNT_W-1:0]  cnt_reg;
    logic [ppss_pkg::CNT_W-1:0]  last;

    logic                        d_v_reg, m_v_reg, q_v_reg, s_v_reg;
    logic [ppss_pkg::PTR_W-1:0]  d_i_reg, m_i_reg, q_i_reg, s_i_reg;
    logic [MW-1:0]               mx_reg, my_reg;
    logic [2*MW-1:0]             qx_reg, qy_reg;
    logic [SW-1:0]               sum_reg;
    logic [SW-1:0]               best_sum_reg;
    logic [ppss_pkg::PTR_W-1:0]  best_reg;

    logic signed [MW:0]          dx, dy;

    // search length: zero means slot 0 only, capped at the table size
    always_comb
    begin
        if (count == '0)
            last = '0;
        else if (count > ppss_pkg::CNT_W'(ppss_pkg::MAX_POINTS))
            last = ppss_pkg::CNT_W'(ppss_pkg::MAX_POINTS - 1);
        else
            last = count - 1'b1;
        dx = (MW+1)'($signed(rx)) - (MW+1)'(px);
        dy = (MW+1)'($signed(ry)) - (MW+1)'(py);
    end

    assign raddr = cnt_reg[ppss_pkg::PTR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            d_v_reg    <= 1'b0;
            m_v_reg    <= 1'b0;
            q_v_reg    <= 1'b0;
            s_v_reg    <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == last)
                begin
                    active_reg <= 1'b0;
                end
            end
            d_v_reg <= active_reg && !start;
            m_v_reg <= d_v_reg;
            q_v_reg <= m_v_reg;
            s_v_reg <= q_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_i_reg <= cnt_reg[ppss_pkg::PTR_W-1:0];
        m_i_reg <= d_i_reg;
        q_i_reg <= m_i_reg;
        s_i_reg <= q_i_reg;
        mx_reg  <= dx[MW] ? MW'(-dx) : MW'(dx);
        my_reg  <= dy[MW] ? MW'(-dy) : MW'(dy);
        qx_reg  <= mx_reg * mx_reg;
        qy_reg  <= my_reg * my_reg;
        sum_reg <= SW'(qx_reg) + SW'(qy_reg);
        if (s_v_reg && (s_i_reg == '0 || sum_reg < best_sum_reg))
        begin
            best_sum_reg <= sum_reg;
            best_reg     <= s_i_reg;
        end
    end

    always_comb
    begin
        status.done = !active_reg && !d_v_reg && !m_v_reg && !q_v_reg && !s_v_reg;
        status.best = best_reg;
    end

endmodule

// File: hdl/pure_pursuit_steering.sv
// Pure pursuit steering: top level sequencer with path store, nearest
// point search and shared CORDIC. Depends on ppss_pkg, ppss_path_ram,
// ppss_cordic and ppss_scan.
`timescale 1ns / 1ps

// Channel   Direction  Request content
// s_*       in         tuser: mode; tdata: point_index, pos_x, pos_y, heading
// m_*       out        tdata: steer_angle, target_slot
// cfg_*     in         register index and value, taken whenever cfg_we is high
//
// A load request writes the path store; ready stays high.
// A steer request holds ready low until its result enters the output register:
// four CORDIC passes (20 steps and a hand-over each), one pipelined pass of the path store
// read port over the slots searched, at one slot a cycle, plus its drain, and sequencing.
// The result waits in an output register; a new request is taken while it
// waits, and a second result is held back until the first is taken.
// Reset is asynchronous, active low; the path store is not cleared.

module pure_pursuit_steering (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // point_index[9:0], pos_x[41:10], pos_y[73:42],
                                  // heading[90:74], zero pad
    input  logic        s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // steer_angle[15:0], target_slot[25:16], zero pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CS     = 4'd1;
    localparam logic [3:0] ST_LAX    = 4'd2;
    localparam logic [3:0] ST_LAY    = 4'd3;
    localparam logic [3:0] ST_LAZ    = 4'd4;
    localparam logic [3:0] ST_SCAN   = 4'd5;
    localparam logic [3:0] ST_SWAIT  = 4'd6;
    localparam logic [3:0] ST_RDB    = 4'd7;
    localparam logic [3:0] ST_RDW    = 4'd8;
    localparam logic [3:0] ST_AT     = 4'd9;
    localparam logic [3:0] ST_AL     = 4'd10;
    localparam logic [3:0] ST_ALRUN  = 4'd11;
    localparam logic [3:0] ST_STR    = 4'd12;
    localparam logic [3:0] ST_STRRUN = 4'd13;
    localparam logic [3:0] ST_OUT    = 4'd14;

    localparam int PW = ppss_pkg::PW;
    localparam int CW = ppss_pkg::CW;
    localparam int ZW = ppss_pkg::ZW;

    // configuration
    logic [15:0]                 ld_reg;
    logic [15:0]                 wb_reg;
    logic [14:0]                 max_reg;
    logic [ppss_pkg::CNT_W-1:0]  count_reg;

    logic [3:0]                  state_reg;

    // request and working values
    logic signed [31:0]          vx_reg, vy_reg;
    logic signed [ZW-1:0]        head_reg;     // heading in Q.20
    logic signed [17:0]          ch_reg, sh_reg, sa_reg;
    logic signed [34:0]          off_reg;
    logic signed [PW-1:0]        px_reg, py_reg;
    logic signed [ZW-1:0]        alpha_reg;
    logic signed [15:0]          steer_reg;

    // output register
    logic                        out_v_reg;
    logic [15:0]                 out_steer_reg;
    logic [ppss_pkg::PTR_W-1:0]  out_slot_reg;

    logic                        s_acc;
    logic                        out_free;
    logic signed [ZW-1:0]        head_in;

    ppss_pkg::cordic_req_t       c_req;
    ppss_pkg::cordic_rsp_t       c_rsp;
    ppss_pkg::scan_status_t      sc_st;

    logic [ppss_pkg::PTR_W-1:0]  scan_addr;
    logic [ppss_pkg::PTR_W-1:0]  raddr;
    logic [31:0]                 rx, ry;

    logic signed [CW-1:0]        cos_r, sin_r;
    logic signed [CW-1:0]        steer_r;
    logic signed [ZW:0]          alpha_w;
    logic signed [35:0]          num;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !out_v_reg || m_tready;
    assign head_in  = {{2{s_tdata[90]}}, s_tdata[90:74], 6'b0};

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'b0, out_slot_reg, out_steer_reg};

    assign raddr = (state_reg == ST_RDB) ? sc_st.best : scan_addr;

    ppss_path_ram u_ram (
        .clk   (clk),
        .we    (s_acc && !s_tuser),
        .waddr (s_tdata[9:0]),
        .wx    (s_tdata[41:10]),
        .wy    (s_tdata[73:42]),
        .raddr (raddr),
        .rx    (rx),
        .ry    (ry)
    );

    ppss_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == ST_SCAN),
        .count  (count_reg),
        .px     (px_reg),
        .py     (py_reg),
        .rx     (rx),
        .ry     (ry),
        .raddr  (scan_addr),
        .status (sc_st)
    );

    ppss_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (c_req),
        .rsp   (c_rsp)
    );

    always_comb
    begin
        // rotation outputs back to Q14, sign folded in
        cos_r   = ppss_pkg::rnd_shr(c_rsp.x, 5'd16);
        sin_r   = ppss_pkg::rnd_shr(c_rsp.y, 5'd16);
        if (c_rsp.neg)
        begin
            cos_r = -cos_r;
            sin_r = -sin_r;
        end
        steer_r = ppss_pkg::rnd_shr(CW'(c_rsp.z), 5'd6);

        // alpha = bearing - heading, wrapped into [-pi, pi]
        alpha_w = (ZW+1)'(c_rsp.z) - (ZW+1)'(head_reg);
        if (alpha_w > (ZW+1)'(ppss_pkg::ANG_PI))
            alpha_w = alpha_w - ((ZW+1)'(ppss_pkg::ANG_PI) <<< 1);
        if (alpha_w > (ZW+1)'(ppss_pkg::ANG_PI))
            alpha_w = alpha_w - ((ZW+1)'(ppss_pkg::ANG_PI) <<< 1);
        if (alpha_w < -(ZW+1)'(ppss_pkg::ANG_PI))
            alpha_w = alpha_w + ((ZW+1)'(ppss_pkg::ANG_PI) <<< 1);
        if (alpha_w < -(ZW+1)'(ppss_pkg::ANG_PI))
            alpha_w = alpha_w + ((ZW+1)'(ppss_pkg::ANG_PI) <<< 1);

        num = 36'($signed({1'b0, wb_reg}) * sa_reg) <<< 1;

        c_req.start = 1'b0;
        c_req.vec   = 1'b0;
        c_req.x     = '0;
        c_req.y     = '0;
        c_req.z     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                c_req.start = s_acc && s_tuser;
                c_req.z     = head_in;
            end
            ST_RDW:
            begin
                c_req.start = 1'b1;
                c_req.vec   = 1'b1;
                c_req.x     = CW'($signed(rx)) - CW'(px_reg);
                c_req.y     = CW'($signed(ry)) - CW'(py_reg);
            end
            ST_AL:
            begin
                c_req.start = 1'b1;
                c_req.z     = alpha_reg;
            end
            ST_STR:
            begin
                c_req.start = 1'b1;
                c_req.vec   = 1'b1;
                c_req.x     = CW'({ld_reg, 14'b0});
                c_req.y     = CW'(num);
            end
            default:
            begin
                c_req.start = 1'b0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_reg    <= 16'd768;
            wb_reg    <= 16'd512;
            max_reg   <= 15'd12868;
            count_reg <= ppss_pkg::CNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppss_pkg::CFG_LOOKAHEAD: ld_reg    <= cfg_data;
                ppss_pkg::CFG_WHEELBASE: wb_reg    <= cfg_data;
                ppss_pkg::CFG_MAXSTEER:  max_reg   <= cfg_data[14:0];
                ppss_pkg::CFG_COUNT:     count_reg <= cfg_data[ppss_pkg::CNT_W-1:0];
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces the one taken in the same cycle
            if (state_reg == ST_OUT && out_free)
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:   if (s_acc && s_tuser) state_reg <= ST_CS;
                ST_CS:     if (c_rsp.done) state_reg <= ST_LAX;
                ST_LAX:    state_reg <= ST_LAY;
                ST_LAY:    state_reg <= ST_LAZ;
                ST_LAZ:    state_reg <= ST_SCAN;
                ST_SCAN:   state_reg <= ST_SWAIT;
                ST_SWAIT:  if (sc_st.done) state_reg <= ST_RDB;
                ST_RDB:    state_reg <= ST_RDW;
                ST_RDW:    state_reg <= ST_AT;
                ST_AT:     if (c_rsp.done) state_reg <= ST_AL;
                ST_AL:     state_reg <= ST_ALRUN;
                ST_ALRUN:  if (c_rsp.done) state_reg <= ST_STR;
                ST_STR:    state_reg <= ST_STRRUN;
                ST_STRRUN: if (c_rsp.done) state_reg <= ST_OUT;
                ST_OUT:    if (out_free) state_reg <= ST_IDLE;
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_acc && s_tuser)
        begin
            vx_reg   <= $signed(s_tdata[41:10]);
            vy_reg   <= $signed(s_tdata[73:42]);
            head_reg <= head_in;
        end
        if (state_reg == ST_CS && c_rsp.done)
        begin
            ch_reg <= cos_r[17:0];
            sh_reg <= sin_r[17:0];
        end
        if (state_reg == ST_LAX)
        begin
            off_reg <= $signed({1'b0, ld_reg}) * ch_reg;
        end
        if (state_reg == ST_LAY)
        begin
            px_reg  <= PW'(vx_reg) + PW'(ppss_pkg::rnd_shr(CW'(off_reg), 5'd6));
            off_reg <= $signed({1'b0, ld_reg}) * sh_reg;
        end
        if (state_reg == ST_LAZ)
        begin
            py_reg <= PW'(vy_reg) + PW'(ppss_pkg::rnd_shr(CW'(off_reg), 5'd6));
        end
        if (state_reg == ST_AT && c_rsp.done)
        begin
            alpha_reg <= alpha_w[ZW-1:0];
        end
        if (state_reg == ST_ALRUN && c_rsp.done)
        begin
            sa_reg <= sin_r[17:0];
        end
        if (state_reg == ST_STRRUN && c_rsp.done)
        begin
            // clamp to the configured magnitude
            if (steer_r > CW'($signed({1'b0, max_reg})))
                steer_reg <= {1'b0, max_reg};
            else if (steer_r < -CW'($signed({1'b0, max_reg})))
                steer_reg <= -{1'b0, max_reg};
            else
                steer_reg <= steer_r[15:0];
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_steer_reg <= steer_reg;
            out_slot_reg  <= sc_st.best;
        end
    end

endmodule

// File: hdl/ppss_checker.sv
// Port checker for pure_pursuit_steering, bound to the top level.
// Depends on pure_pursuit_steering_assert.svh.
`timescale 1ns / 1ps
`include "pure_pursuit_steering_assert.svh"

module ppss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `PPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `PPS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
    `PPS_ASSERT_NEXT(a_steer_busy, s_tvalid && s_tready && s_tuser, !s_tready, "steer request not held off")
    `PPS_ASSERT_NEXT(a_load_ready, s_tvalid && s_tready && !s_tuser, s_tready, "load request stalled the input")
    `PPS_ASSERT_CLK(a_pad_zero, m_tvalid |-> m_tdata[31:26] == 6'd0, "result padding not zero")

endmodule

bind pure_pursuit_steering ppss_checker u_ppss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
